### sv/fst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fst_pkg;

  // default number of table slots
  localparam int unsigned DefaultDepth = 128;

  // result status codes
  localparam logic [1:0] StAppended = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StFound    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  // input function codes
  localparam logic FnAppend = 1'b0;
  localparam logic FnSearch = 1'b1;

endpackage

`default_nettype wire

### sv/fibonacci_search_table.sv
// an append passes from the input beat to S_DONE and then to the output register; a search
//   builds fibonacci terms past the entry count, then probes, and may check a final slot
// each probe is a read state and then a compare state on the one table read port
// throughput: one item at a time, the input is not ready until the result is staged
// reset: asynchronous active low, clears the entry count and control; the key table
//   is not cleared, only slots below the entry count are ever read
`timescale 1ns / 1ps
`default_nettype none

module fibonacci_search_table #(
  parameter int unsigned TABLE_DEPTH = fst_pkg::DefaultDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input beats
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] key (signed)
  input  wire logic        s_axis_tuser,   // [0] func
  // result beats
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [6:0] position, [7] zero
  output      logic [1:0]  m_axis_tuser    // [1:0] status
);

  // address, entry count, fibonacci term and probe sum widths
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FW = CW + 1;
  localparam int unsigned PW = CW + 2;
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GROW = 3'd1;  // build fibonacci terms past the count
  localparam logic [2:0] S_PRD  = 3'd2;  // issue probe read
  localparam logic [2:0] S_PCMP = 3'd3;  // compare probe and step terms
  localparam logic [2:0] S_FRD  = 3'd4;  // issue final slot read
  localparam logic [2:0] S_FCMP = 3'd5;  // compare final slot
  localparam logic [2:0] S_DONE = 3'd6;  // hand result to output register

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   key_q;
  logic [FW-1:0] fa_q, fa_d, fb_q, fb_d, fm_q, fm_d;
  logic [CW-1:0] bp1_q, bp1_d;      // search base plus one, so it never goes negative
  logic [CW-1:0] probe_q, probe_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [CW-1:0] res_slot_q, res_slot_d;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [6:0]    out_pos_q;

  // key table
  logic [31:0]   mem_q [TABLE_DEPTH];
  logic [31:0]   rdata_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // shared arithmetic
  logic [FW-1:0] fsub;             // fb - fa, used by both step directions
  logic [PW-1:0] probe_sum;        // base + fa, plus one
  logic [CW-1:0] probe_c;          // clamped probe slot
  logic          in_beat;
  logic          out_free;
  logic [CW+6:0] slot_ext;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign fsub      = fb_q - fa_q;
  assign probe_sum = PW'(bp1_q) + PW'(fa_q);

  // probe = base + fa clamped to 0 .. count-1
  always_comb begin
    if (probe_sum == '0) begin
      probe_c = '0;
    end else if (probe_sum > PW'(count_q)) begin
      probe_c = count_q - CW'(1);
    end else begin
      probe_c = CW'(probe_sum - PW'(1));
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    fa_d         = fa_q;
    fb_d         = fb_q;
    fm_d         = fm_q;
    bp1_d        = bp1_q;
    probe_d      = probe_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    rd_en        = 1'b0;
    rd_addr      = probe_c[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          fa_d       = '0;
          fb_d       = FW'(1);
          fm_d       = FW'(1);
          bp1_d      = '0;
          res_slot_d = '0;
          if (s_axis_tuser == fst_pkg::FnAppend) begin
            if (count_q < Depth) begin
              wr_en        = 1'b1;
              res_slot_d   = count_q;
              count_d      = count_q + CW'(1);
              res_status_d = fst_pkg::StAppended;
            end else begin
              res_status_d = fst_pkg::StFull;
            end
            state_d = S_DONE;
          end else if (count_q == '0) begin
            // empty table answers without probing
            res_status_d = fst_pkg::StNotFound;
            state_d      = S_DONE;
          end else begin
            state_d = S_GROW;
          end
        end
      end

      S_GROW: begin
        if (fm_q < FW'(count_q)) begin
          fa_d = fb_q;
          fb_d = fm_q;
          fm_d = fb_q + fm_q;
        end else if (fm_q > FW'(1)) begin
          state_d = S_PRD;
        end else begin
          state_d = S_FRD;
        end
      end

      S_PRD: begin
        rd_en   = 1'b1;
        probe_d = probe_c;
        state_d = S_PCMP;
      end

      S_PCMP: begin
        if ($signed(rdata_q) < $signed(key_q)) begin
          fm_d  = fb_q;
          fb_d  = fa_q;
          fa_d  = fsub;
          bp1_d = probe_q + CW'(1);
          state_d = (fb_q > FW'(1)) ? S_PRD : S_FRD;
        end else if ($signed(rdata_q) > $signed(key_q)) begin
          fm_d  = fa_q;
          fb_d  = fsub;
          fa_d  = fa_q - fsub;
          state_d = (fa_q > FW'(1)) ? S_PRD : S_FRD;
        end else begin
          res_status_d = fst_pkg::StFound;
          res_slot_d   = probe_q;
          state_d      = S_DONE;
        end
      end

      S_FRD: begin
        // last slot is checked only when it lies below the count
        rd_addr = bp1_q[AW-1:0];
        if (fb_q != '0 && bp1_q < count_q) begin
          rd_en   = 1'b1;
          state_d = S_FCMP;
        end else begin
          res_status_d = fst_pkg::StNotFound;
          state_d      = S_DONE;
        end
      end

      S_FCMP: begin
        if (rdata_q == key_q) begin
          res_status_d = fst_pkg::StFound;
          res_slot_d   = bp1_q;
        end else begin
          res_status_d = fst_pkg::StNotFound;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      key_q <= s_axis_tdata;
    end
    fa_q         <= fa_d;
    fb_q         <= fb_d;
    fm_q         <= fm_d;
    bp1_q        <= bp1_d;
    probe_q      <= probe_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
  end

  // position carries the low seven bits of the slot
  assign slot_ext = {7'b0, res_slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= fst_pkg::StAppended;
      out_pos_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_pos_q    <= slot_ext[6:0];
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pos_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire
